// ===== sv/hrlf_pkg.sv =====
`default_nettype none

package hrlf_pkg;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes, taken from paddr[2]
  localparam logic REG_FIRST_LINE_LIMIT = 1'b0;
  localparam logic REG_BODY_LIMIT       = 1'b1;

  localparam logic [15:0] FIRST_LINE_LIMIT_RST = 16'd1024;
  localparam logic [23:0] BODY_LIMIT_RST       = 24'd1048576;

  // Result field widths
  localparam int LEN_W = 32;

  // Content-length value arithmetic
  localparam int VAL_W = 25;
  localparam logic [VAL_W-1:0] VALUE_SAT = 25'h1000000;
  localparam logic [VAL_W-1:0] NEG_MARK  = 25'h1FFFFFF;
  localparam logic [4:0] NAME_LEN = 5'd15;
  localparam logic [4:0] POS_MAX  = 5'd31;

  // Characters
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_SP       = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    VP_SKIP   = 2'd0,
    VP_SIGN   = 2'd1,
    VP_DIGITS = 2'd2,
    VP_DONE   = 2'd3
  } vphase_t;

  typedef enum logic [1:0] {
    ST_NEED  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] first_line_limit;
    logic [23:0] body_limit;
  } cfg_t;

  // Lower-case header name "content-length:", one character per position
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hrlf_if.sv =====
`default_nettype none

interface hrlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source(output valid, output data_byte, output stream_start, input ready);
  modport sink(input valid, input data_byte, input stream_start, output ready);
endinterface

interface hrlf_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   frame_status;
  logic [hrlf_pkg::LEN_W-1:0]   request_length;

  modport source(output valid, output frame_status, output request_length, input ready);
  modport sink(input valid, input frame_status, input request_length, output ready);
endinterface

`default_nettype wire

// ===== sv/hrlf_cfg.sv =====
`default_nettype none

module hrlf_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [hrlf_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [hrlf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [hrlf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output hrlf_pkg::cfg_t                       cfg
);

  logic [15:0] first_line_limit_r, first_line_limit_nxt;
  logic [23:0] body_limit_r, body_limit_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    first_line_limit_nxt = first_line_limit_r;
    body_limit_nxt       = body_limit_r;
    if (wr_en) begin
      case (paddr[2])
        hrlf_pkg::REG_FIRST_LINE_LIMIT: first_line_limit_nxt = pwdata[15:0];
        hrlf_pkg::REG_BODY_LIMIT:       body_limit_nxt       = pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_line_limit_r <= hrlf_pkg::FIRST_LINE_LIMIT_RST;
      body_limit_r       <= hrlf_pkg::BODY_LIMIT_RST;
    end else begin
      first_line_limit_r <= first_line_limit_nxt;
      body_limit_r       <= body_limit_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      hrlf_pkg::REG_FIRST_LINE_LIMIT: prdata = {16'd0, first_line_limit_r};
      hrlf_pkg::REG_BODY_LIMIT:       prdata = {8'd0, body_limit_r};
      default:                        prdata = '0;
    endcase
  end

  assign cfg.first_line_limit = first_line_limit_r;
  assign cfg.body_limit       = body_limit_r;

endmodule

`default_nettype wire

// ===== sv/hrlf_core.sv =====
`default_nettype none

module hrlf_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        stream_start,
  input  hrlf_pkg::cfg_t                   cfg,
  output hrlf_pkg::status_t                frame_status,
  output logic [hrlf_pkg::LEN_W-1:0]       request_length
);

  localparam int VW    = hrlf_pkg::VAL_W;
  localparam int SUM_W = ((COUNT_WIDTH > VW) ? COUNT_WIDTH : VW) + 1;
  localparam int MUL_W = VW + 4;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // State registers
  hrlf_pkg::phase_t       phase_r, phase_nxt;
  logic                   prev_cr_r, prev_cr_nxt;
  logic [COUNT_WIDTH-1:0] byte_count_r, byte_count_nxt;
  logic [4:0]             line_pos_r, line_pos_nxt;
  logic                   starts_cr_r, starts_cr_nxt;
  logic                   name_ok_r, name_ok_nxt;
  hrlf_pkg::vphase_t      vphase_r, vphase_nxt;
  logic                   neg_r, neg_nxt;
  logic [VW-1:0]          accum_r, accum_nxt;
  logic [VW-1:0]          body_len_r, body_len_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;

  // State as seen by this byte, after an optional stream restart
  hrlf_pkg::phase_t       phase_c;
  logic                   prev_cr_c;
  logic [COUNT_WIDTH-1:0] byte_count_c;
  logic [4:0]             line_pos_c;
  logic                   starts_cr_c;
  logic                   name_ok_c;
  hrlf_pkg::vphase_t      vphase_c;
  logic                   neg_c;
  logic [VW-1:0]          accum_c;
  logic [VW-1:0]          body_len_c;
  logic [COUNT_WIDTH-1:0] total_c;

  logic [7:0]             lc;
  logic                   is_digit;
  logic                   is_space;
  logic [4:0]             name_len;
  logic [MUL_W-1:0]       accum_wide;
  logic [SUM_W-1:0]       sum;
  hrlf_pkg::vphase_t      vp_tmp;
  logic                   done_now;
  hrlf_pkg::status_t      status;

  always_comb begin
    if (stream_start) begin
      phase_c      = hrlf_pkg::PH_FIRST;
      prev_cr_c    = 1'b0;
      byte_count_c = '0;
      line_pos_c   = '0;
      starts_cr_c  = 1'b0;
      name_ok_c    = 1'b1;
      vphase_c     = hrlf_pkg::VP_SKIP;
      neg_c        = 1'b0;
      accum_c      = '0;
      body_len_c   = '0;
      total_c      = '0;
    end else begin
      phase_c      = phase_r;
      prev_cr_c    = prev_cr_r;
      byte_count_c = byte_count_r;
      line_pos_c   = line_pos_r;
      starts_cr_c  = starts_cr_r;
      name_ok_c    = name_ok_r;
      vphase_c     = vphase_r;
      neg_c        = neg_r;
      accum_c      = accum_r;
      body_len_c   = body_len_r;
      total_c      = total_r;
    end
  end

  assign lc = (data_byte >= hrlf_pkg::CH_UPPER_A && data_byte <= hrlf_pkg::CH_UPPER_Z) ?
              data_byte + hrlf_pkg::CASE_OFFSET : data_byte;
  assign is_digit = (data_byte >= hrlf_pkg::CH_ZERO) && (data_byte <= hrlf_pkg::CH_NINE);
  assign is_space = (data_byte == hrlf_pkg::CH_SP) || (data_byte == hrlf_pkg::CH_TAB) ||
                    (data_byte == hrlf_pkg::CH_CR) || (data_byte == hrlf_pkg::CH_VT) ||
                    (data_byte == hrlf_pkg::CH_FF);
  assign name_len = line_pos_c - {4'd0, prev_cr_c};
  assign accum_wide = (MUL_W'(accum_c) << 3) + (MUL_W'(accum_c) << 1) +
                      MUL_W'(data_byte[3:0]);
  assign sum = SUM_W'(byte_count_nxt) + SUM_W'(body_len_c);

  always_comb begin
    phase_nxt      = phase_c;
    prev_cr_nxt    = (data_byte == hrlf_pkg::CH_CR);
    byte_count_nxt = (byte_count_c == CNT_MAX) ? byte_count_c :
                     byte_count_c + COUNT_WIDTH'(1);
    line_pos_nxt   = line_pos_c;
    starts_cr_nxt  = starts_cr_c;
    name_ok_nxt    = name_ok_c;
    vphase_nxt     = vphase_c;
    neg_nxt        = neg_c;
    accum_nxt      = accum_c;
    body_len_nxt   = body_len_c;
    total_nxt      = total_c;
    done_now       = 1'b0;
    vp_tmp         = vphase_c;

    case (phase_c)
      hrlf_pkg::PH_FIRST: begin
        if (prev_cr_c && data_byte == hrlf_pkg::CH_LF) begin
          phase_nxt     = hrlf_pkg::PH_HEADER;
          line_pos_nxt  = '0;
          starts_cr_nxt = 1'b0;
          name_ok_nxt   = 1'b1;
          vphase_nxt    = hrlf_pkg::VP_SKIP;
          neg_nxt       = 1'b0;
          accum_nxt     = '0;
        end else if (byte_count_nxt > COUNT_WIDTH'(cfg.first_line_limit)) begin
          phase_nxt = hrlf_pkg::PH_ERROR;
        end
      end
      hrlf_pkg::PH_HEADER: begin
        if (data_byte == hrlf_pkg::CH_LF) begin
          if (line_pos_c == 5'd1 && starts_cr_c) begin
            // Blank line: header ends here
            if (body_len_c > VW'(cfg.body_limit)) begin
              phase_nxt = hrlf_pkg::PH_ERROR;
            end else begin
              phase_nxt = hrlf_pkg::PH_BODY;
              total_nxt = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[COUNT_WIDTH-1:0];
              // Total reaches the count now only for an empty body or a pinned count
              done_now  = (body_len_c == '0) || (byte_count_nxt == CNT_MAX);
            end
          end else begin
            if (line_pos_c != '0 && name_ok_c && name_len > hrlf_pkg::NAME_LEN) begin
              body_len_nxt = (neg_c && accum_c != '0) ? hrlf_pkg::NEG_MARK : accum_c;
            end
            line_pos_nxt  = '0;
            starts_cr_nxt = 1'b0;
            name_ok_nxt   = 1'b1;
            vphase_nxt    = hrlf_pkg::VP_SKIP;
            neg_nxt       = 1'b0;
            accum_nxt     = '0;
          end
        end else begin
          if (line_pos_c == '0) starts_cr_nxt = (data_byte == hrlf_pkg::CH_CR);
          if (line_pos_c < hrlf_pkg::NAME_LEN) begin
            if (lc != hrlf_pkg::name_char(line_pos_c[3:0])) name_ok_nxt = 1'b0;
          end else begin
            case (vphase_c)
              hrlf_pkg::VP_SKIP: begin
                if (is_space) begin
                  vp_tmp = hrlf_pkg::VP_SKIP;
                end else if (data_byte == hrlf_pkg::CH_PLUS ||
                             data_byte == hrlf_pkg::CH_MINUS) begin
                  neg_nxt = (data_byte == hrlf_pkg::CH_MINUS);
                  vp_tmp  = hrlf_pkg::VP_SIGN;
                end else begin
                  vp_tmp = is_digit ? hrlf_pkg::VP_DIGITS : hrlf_pkg::VP_DONE;
                end
              end
              hrlf_pkg::VP_SIGN:   vp_tmp = is_digit ? hrlf_pkg::VP_DIGITS : hrlf_pkg::VP_DONE;
              hrlf_pkg::VP_DIGITS: vp_tmp = is_digit ? hrlf_pkg::VP_DIGITS : hrlf_pkg::VP_DONE;
              default:             vp_tmp = vphase_c;
            endcase
            vphase_nxt = vp_tmp;
            if (vp_tmp == hrlf_pkg::VP_DIGITS) begin
              accum_nxt = (accum_wide > MUL_W'(hrlf_pkg::VALUE_SAT)) ?
                          hrlf_pkg::VALUE_SAT : accum_wide[VW-1:0];
            end
          end
          if (line_pos_c < hrlf_pkg::POS_MAX) line_pos_nxt = line_pos_c + 5'd1;
        end
      end
      default: ;
    endcase

    if (phase_nxt == hrlf_pkg::PH_BODY &&
        (done_now || (phase_c == hrlf_pkg::PH_BODY && byte_count_nxt >= total_c))) begin
      status = hrlf_pkg::ST_DONE;
    end else if (phase_nxt == hrlf_pkg::PH_ERROR) begin
      status = hrlf_pkg::ST_ERROR;
    end else begin
      status = hrlf_pkg::ST_NEED;
    end
  end

  assign frame_status   = status;
  assign request_length = (status == hrlf_pkg::ST_DONE) ? hrlf_pkg::LEN_W'(total_nxt) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hrlf_pkg::PH_FIRST;
      prev_cr_r    <= 1'b0;
      byte_count_r <= '0;
      line_pos_r   <= '0;
      starts_cr_r  <= 1'b0;
      name_ok_r    <= 1'b1;
      vphase_r     <= hrlf_pkg::VP_SKIP;
      neg_r        <= 1'b0;
      accum_r      <= '0;
      body_len_r   <= '0;
      total_r      <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      prev_cr_r    <= prev_cr_nxt;
      byte_count_r <= byte_count_nxt;
      line_pos_r   <= line_pos_nxt;
      starts_cr_r  <= starts_cr_nxt;
      name_ok_r    <= name_ok_nxt;
      vphase_r     <= vphase_nxt;
      neg_r        <= neg_nxt;
      accum_r      <= accum_nxt;
      body_len_r   <= body_len_nxt;
      total_r      <= total_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/http_request_length_framer.sv =====
// HTTP request framer: takes the bytes of a request stream one per request on in_req and
// returns one result per byte on out_rsp: need more (0), complete at this byte (1) with the
// header-plus-body length, or error (2). The first line must end in CR LF within
// first_line_limit bytes; the header ends at a line holding only CR LF; the last
// "Content-Length:" line (case-insensitive) sets the body length, which must not exceed
// body_limit. After completion or error every byte repeats that result until a byte
// arrives with stream_start set, which restarts parsing at that byte. Throughput is one
// byte per clock while out_rsp takes results; a result passes from the input register
// through the combinational parse step into the result register, and a byte waits in
// the input register while the result register is full and not being drained.
// Registers over APB: 0x0 first_line_limit[15:0], 0x4 body_limit[23:0].

`default_nettype none

module http_request_length_framer #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  hrlf_in_if.sink                              in_req,
  hrlf_out_if.source                           out_rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [hrlf_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [hrlf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [hrlf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  hrlf_pkg::cfg_t cfg;

  // Input register: holds one request until the parse step can take it
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // Result register
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r;
  logic [hrlf_pkg::LEN_W-1:0] out_len_r;

  logic                       advance;
  hrlf_pkg::status_t          core_status;
  logic [hrlf_pkg::LEN_W-1:0] core_len;

  hrlf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held byte whenever the result register is free or being drained
  assign advance      = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_req.valid && in_req.ready) s1_valid_nxt = 1'b1;
    else if (advance)                 s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload: capture on accept, no reset needed
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_byte_r  <= in_req.data_byte;
      s1_start_r <= in_req.stream_start;
    end
  end

  // Parse step: updates stream state only when the byte moves to the result register
  hrlf_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .data_byte      (s1_byte_r),
    .stream_start   (s1_start_r),
    .cfg            (cfg),
    .frame_status   (core_status),
    .request_length (core_len)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance)            out_valid_nxt = 1'b1;
    else if (out_rsp.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= core_status;
      out_len_r    <= core_len;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.frame_status   = out_status_r;
  assign out_rsp.request_length = out_len_r;

endmodule

`default_nettype wire
